// ===== rtl/i2c_bus_master_assert.svh =====
// Assertion macros for the I2C bus master RTL.
// Header only; included by modules that carry concurrent checks.
`ifndef I2C_BUS_MASTER_ASSERT_SVH
`define I2C_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and codes for the I2C bus master.
// No dependencies; compiled before the interfaces and modules.
`default_nettype none

package i2cm_pkg;

   // line phases of the bus sequencer
   typedef enum logic [4:0] {
      PH_IDLE  = 5'd0,
      PH_ST_A  = 5'd1,
      PH_ST_B  = 5'd2,
      PH_ST_C  = 5'd3,
      PH_ST_D  = 5'd4,
      PH_SP_A  = 5'd5,
      PH_SP_B  = 5'd6,
      PH_SP_C  = 5'd7,
      PH_WR_D  = 5'd8,
      PH_WR_H  = 5'd9,
      PH_WR_L  = 5'd10,
      PH_WR_AS = 5'd11,
      PH_WR_AH = 5'd12,
      PH_RD_H  = 5'd13,
      PH_RD_L  = 5'd14,
      PH_AK_D  = 5'd15,
      PH_NK_D  = 5'd16,
      PH_AK_H  = 5'd17,
      PH_AK_L  = 5'd18
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_BUSY  = 3'd1,
      ST_ERROR = 3'd2,
      ST_ACK   = 3'd3,
      ST_NACK  = 3'd4
   } status_type;

   // command codes
   localparam logic [2:0] FUNC_START = 3'd0;
   localparam logic [2:0] FUNC_STOP  = 3'd1;
   localparam logic [2:0] FUNC_WRITE = 3'd2;
   localparam logic [2:0] FUNC_READ  = 3'd3;
   localparam logic [2:0] FUNC_ACK   = 3'd4;
   localparam logic [2:0] FUNC_NACK  = 3'd5;

   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
   localparam logic [15:0] WAIT_RESET    = 16'd5;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic [2:0] status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/i2cm_if.sv =====
// Valid/ready channel interfaces for the I2C bus master.
// Depends on nothing; payload widths fixed by the request/result formats.
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] func;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, cmd_valid, func, tx_byte, sda_in, input ready);
   modport sink   (input valid, cmd_valid, func, tx_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic [2:0] status;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, status,
                   input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, status,
                   output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_bus_master.sv =====
// I2C bus master top level: channel wiring, sequencer and result register.
// Depends on i2cm_pkg, i2cm_if.sv, i2cm_seq and i2cm_rsp_reg.
//
//   channel   dir   handshake          carries
//   req_ch    in    valid / ready      cmd_valid, func, tx_byte, sda_in (one bus tick)
//   rsp_ch    out   valid / ready      scl_out, sda_out, busy_res, done_res, rx_byte, status
//   csr_ch    in    valid / ready      phase_wait_ticks (16 bit)
//
// Every request is one sequencer tick and yields exactly one result.
// The result is registered: the tick's next-state logic feeds the result register.
// A request can be taken every cycle while results drain; the result register is the only stage.
// A stalled result blocks new requests only while it is still waiting.
// Reset (synchronous, high): bus idle, both lines released, wait reload 5.
// csr_ch is always ready; writes land on the next edge.
`default_nettype none

module i2c_bus_master (
   input  wire logic  clock,
   input  wire logic  reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch,
   i2cm_csr_if.sink   csr_ch
);
   import i2cm_pkg::*;

   logic    req_ready;
   logic    step;
   req_type req;
   rsp_type rsp_next;
   rsp_type rsp_cur;
   logic    rsp_valid;

   // request accepted: advance the sequencer one tick
   assign req_ch.ready = req_ready;
   assign step         = req_ch.valid && req_ready;

   assign req.cmd_valid = req_ch.cmd_valid;
   assign req.func      = req_ch.func;
   assign req.tx_byte   = req_ch.tx_byte;
   assign req.sda_in    = req_ch.sda_in;

   // register writes need no back-pressure
   assign csr_ch.ready = 1'b1;

   i2cm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req      (req),
      .csr_we   (csr_ch.valid),
      .csr_data (csr_ch.data),
      .rsp      (rsp_next)
   );

   i2cm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .rsp_in    (rsp_next),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_valid),
      .rsp_out   (rsp_cur),
      .in_ready  (req_ready)
   );

   assign rsp_ch.valid    = rsp_valid;
   assign rsp_ch.scl_out  = rsp_cur.scl_out;
   assign rsp_ch.sda_out  = rsp_cur.sda_out;
   assign rsp_ch.busy_res = rsp_cur.busy_res;
   assign rsp_ch.done_res = rsp_cur.done_res;
   assign rsp_ch.rx_byte  = rsp_cur.rx_byte;
   assign rsp_ch.status   = rsp_cur.status;

endmodule

`default_nettype wire

// ===== rtl/i2cm_seq.sv =====
// Bus phase sequencer: state registers plus one-tick next-state logic.
// Depends on i2cm_pkg and i2c_bus_master_assert.svh.
`default_nettype none
`include "i2c_bus_master_assert.svh"

module i2cm_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,       // one request accepted this cycle
   input  wire i2cm_pkg::req_type req,
   input  wire logic             csr_we,
   input  wire logic [15:0]      csr_data,
   output i2cm_pkg::rsp_type     rsp         // result for the stepped tick
);
   import i2cm_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  tx_hold_ff, tx_hold_in;
   logic [15:0] wait_ff, wait_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   status_type  status_ff, status_in;
   logic [15:0] phase_wait_ff;

   logic        enter_en;
   phase_type   enter_ph;
   logic        fin_en;
   status_type  fin_st;
   logic        done;
   logic [15:0] wait_load;
   logic        cmd_ok;

   // zero wait acts as one
   assign wait_load = (phase_wait_ff == 16'd0) ? 16'd0 : phase_wait_ff - 16'd1;
   assign cmd_ok    = req.cmd_valid && (req.func inside {[FUNC_START:FUNC_NACK]});

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      tx_hold_in   = tx_hold_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      status_in    = status_ff;
      enter_en     = 1'b0;
      enter_ph     = PH_IDLE;
      fin_en       = 1'b0;
      fin_st       = ST_OK;

      if (phase_ff == PH_IDLE) begin
         if (cmd_ok) begin
            bit_count_in = 4'd0;
            enter_en     = 1'b1;
            case (req.func)
               FUNC_START: enter_ph = PH_ST_A;
               FUNC_STOP:  enter_ph = PH_SP_A;
               FUNC_WRITE: begin
                  tx_hold_in = req.tx_byte;
                  enter_ph   = PH_WR_D;
               end
               FUNC_READ: begin
                  shift_in = 8'd0;
                  enter_ph = PH_RD_H;
               end
               FUNC_ACK:   enter_ph = PH_AK_D;
               default:    enter_ph = PH_NK_D;
            endcase
         end
      end else if (wait_ff != 16'd0) begin
         wait_in = wait_ff - 16'd1;
      end else begin
         case (phase_ff)
            PH_ST_A: begin enter_en = 1'b1; enter_ph = PH_ST_B; end
            PH_ST_B: begin
               if (!req.sda_in) begin
                  fin_en = 1'b1;
                  fin_st = ST_BUSY;
               end else begin
                  enter_en = 1'b1;
                  enter_ph = PH_ST_C;
               end
            end
            PH_ST_C: begin enter_en = 1'b1; enter_ph = PH_ST_D; end
            PH_ST_D: begin
               fin_en = 1'b1;
               fin_st = req.sda_in ? ST_ERROR : ST_OK;
            end
            PH_SP_A: begin enter_en = 1'b1; enter_ph = PH_SP_B; end
            PH_SP_B: begin enter_en = 1'b1; enter_ph = PH_SP_C; end
            PH_SP_C: begin fin_en = 1'b1; fin_st = ST_OK; end
            PH_WR_D: begin enter_en = 1'b1; enter_ph = PH_WR_H; end
            PH_WR_H: begin enter_en = 1'b1; enter_ph = PH_WR_L; end
            PH_WR_L: begin
               tx_hold_in   = {tx_hold_ff[6:0], 1'b0};
               bit_count_in = bit_count_ff + 4'd1;
               enter_en     = 1'b1;
               enter_ph     = (bit_count_in >= BITS_PER_BYTE) ? PH_WR_AS : PH_WR_D;
            end
            PH_WR_AS: begin enter_en = 1'b1; enter_ph = PH_WR_AH; end
            PH_WR_AH: begin
               scl_in = 1'b0;
               fin_en = 1'b1;
               fin_st = req.sda_in ? ST_NACK : ST_ACK;
            end
            PH_RD_H: begin
               shift_in = {shift_ff[6:0], req.sda_in};
               enter_en = 1'b1;
               enter_ph = PH_RD_L;
            end
            PH_RD_L: begin
               bit_count_in = bit_count_ff + 4'd1;
               if (bit_count_in >= BITS_PER_BYTE) begin
                  fin_en = 1'b1;
                  fin_st = ST_OK;
               end else begin
                  enter_en = 1'b1;
                  enter_ph = PH_RD_H;
               end
            end
            PH_AK_D, PH_NK_D: begin enter_en = 1'b1; enter_ph = PH_AK_H; end
            PH_AK_H: begin enter_en = 1'b1; enter_ph = PH_AK_L; end
            PH_AK_L: begin fin_en = 1'b1; fin_st = ST_OK; end
            default: begin fin_en = 1'b1; fin_st = ST_OK; end
         endcase
      end

      // line drive on phase entry
      if (enter_en) begin
         phase_in = enter_ph;
         wait_in  = wait_load;
         case (enter_ph)
            PH_ST_A:  sda_in = 1'b1;
            PH_ST_B:  scl_in = 1'b1;
            PH_ST_C:  sda_in = 1'b0;
            PH_ST_D:  scl_in = 1'b0;
            PH_SP_A:  sda_in = 1'b0;
            PH_SP_B:  scl_in = 1'b1;
            PH_SP_C:  sda_in = 1'b1;
            PH_WR_D: begin
               scl_in = 1'b0;
               sda_in = tx_hold_in[7];
            end
            PH_WR_H:  scl_in = 1'b1;
            PH_WR_L:  scl_in = 1'b0;
            PH_WR_AS: sda_in = 1'b1;
            PH_WR_AH: scl_in = 1'b1;
            PH_RD_H: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            PH_RD_L:  scl_in = 1'b0;
            PH_AK_D:  sda_in = 1'b0;
            PH_NK_D:  sda_in = 1'b1;
            PH_AK_H:  scl_in = 1'b1;
            PH_AK_L:  scl_in = 1'b0;
            default:  ;
         endcase
      end

      if (fin_en) begin
         phase_in  = PH_IDLE;
         wait_in   = 16'd0;
         status_in = fin_st;
      end
   end

   assign done = fin_en;

   always_comb begin
      rsp.scl_out  = scl_in;
      rsp.sda_out  = sda_in;
      rsp.busy_res = (phase_in != PH_IDLE);
      rsp.done_res = done;
      rsp.rx_byte  = shift_in;
      rsp.status   = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         tx_hold_ff    <= 8'd0;
         wait_ff       <= 16'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         status_ff     <= ST_OK;
         phase_wait_ff <= WAIT_RESET;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            tx_hold_ff   <= tx_hold_in;
            wait_ff      <= wait_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            status_ff    <= status_in;
         end
         if (csr_we) begin
            phase_wait_ff <= csr_data;
         end
      end
   end

   `I2CM_ASSERT_IMP(a_done_idle, step && done, phase_in == PH_IDLE,
      "command finished but sequencer not idle")
   `I2CM_ASSERT_NXT(a_hold_phase, step && (phase_ff != PH_IDLE) && (wait_ff != 16'd0),
      phase_ff == $past(phase_ff), "phase changed during its hold")
   `I2CM_ASSERT_IMP(a_bit_range, 1'b1, bit_count_ff <= BITS_PER_BYTE,
      "bit counter past one byte")
   `I2CM_ASSERT_NXT(a_ignore_bad, step && (phase_ff == PH_IDLE) && !cmd_ok,
      phase_ff == PH_IDLE, "idle sequencer left idle without a valid command")

endmodule

`default_nettype wire

// ===== rtl/i2cm_rsp_reg.sv =====
// Result register: holds one result and decouples the two handshakes.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_rsp_reg (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire i2cm_pkg::rsp_type rsp_in,
   input  wire logic         out_ready,
   output logic              out_valid,
   output i2cm_pkg::rsp_type rsp_out,
   output logic              in_ready
);
   import i2cm_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // a new result may enter when the slot is empty or drains this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign rsp_out   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
